// ===== rtl/srast_pkg.sv =====
// shared constants, types and the command word passed from front to back
// of the segment overlap rasterizer; no dependencies
`default_nettype none

package srast_pkg;

  localparam int GRID_SIDE = 1024;
  localparam int COORD_W   = 10;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int HIT_W     = 2;
  localparam int TOTAL_W   = 21;

  localparam logic [HIT_W-1:0]   HIT_ONE   = HIT_W'(1);
  localparam logic [HIT_W-1:0]   HIT_SAT   = HIT_W'(2);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_AW-1:0] cell_addr_t;

  // one classified segment: start cell, per-step address offset, steps left
  typedef struct packed {
    logic       rejected;
    cell_addr_t start_addr;
    cell_addr_t step;
    coord_t     len;
  } seg_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/segment_overlap_rasterizer.sv =====
// top level of the segment overlap rasterizer: front classifier and queue,
// back walker with the hit grid ram; uses srast_pkg, srast_front, srast_back
//
//   channel  direction  handshake          word
//   in       input      in_valid/in_stall  start_x, start_y, end_x, end_y (10 bits each)
//   out      output     out_valid/out_stall overlap_cells (21 bits), rejected (1 bit)
//
// a drawn segment walks len + 1 cells in the back end, len = max(|dx|, |dy|),
// with one read-modify-write of the hit ram per cell; a rejected one is not walked
// after reset the hit ram is cleared one cell a cycle, all GRID_SIDE*GRID_SIDE
// cells (1048576), while in_stall stays high
// a two-entry queue lets the front take segments while the back is walking
// a result held by out_stall blocks only the next result, not the queue
`default_nettype none

module segment_overlap_rasterizer (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire srast_pkg::coord_t        in_start_x,
  input  wire srast_pkg::coord_t        in_start_y,
  input  wire srast_pkg::coord_t        in_end_x,
  input  wire srast_pkg::coord_t        in_end_y,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [srast_pkg::TOTAL_W-1:0] out_overlap_cells,
  output logic                          out_rejected
);

  import srast_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  seg_cmd_t cmd;
  logic     clear_busy;

  srast_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .hold       (clear_busy),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  srast_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_overlap_cells (out_overlap_cells),
    .out_rejected      (out_rejected)
  );

  // no segment may enter while the grid is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> in_stall)
    else $error("segment accepted during grid clear");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !cmd_pop && !out_valid)
    else $error("back end active during grid clear");

endmodule

`default_nettype wire

// ===== rtl/srast_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no package dependencies
`default_nettype none

module srast_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srast_front.sv =====
// front end: accepts segments, classifies slope and range, computes the start
// cell and step, and queues commands for the back end; uses srast_pkg
`default_nettype none

module srast_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire srast_pkg::coord_t    in_start_x,
  input  wire srast_pkg::coord_t    in_start_y,
  input  wire srast_pkg::coord_t    in_end_x,
  input  wire srast_pkg::coord_t    in_end_y,
  input  wire logic                 hold,
  output logic                      cmd_valid,
  output srast_pkg::seg_cmd_t       cmd,
  input  wire logic                 cmd_pop
);

  import srast_pkg::*;

  localparam cell_addr_t ROW_STEP = CELL_AW'(GRID_SIDE);
  localparam cell_addr_t COL_STEP = CELL_AW'(1);

  coord_t     dx, dy;
  logic       off_grid, bad_slope;
  logic       xup, yup;
  cell_addr_t xstep, ystep;
  seg_cmd_t   new_cmd;
  logic       push;

  seg_cmd_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    xup = in_end_x >= in_start_x;
    yup = in_end_y >= in_start_y;
    dx  = xup ? in_end_x - in_start_x : in_start_x - in_end_x;
    dy  = yup ? in_end_y - in_start_y : in_start_y - in_end_y;
    off_grid = (32'(in_start_x) >= 32'(GRID_SIDE)) || (32'(in_start_y) >= 32'(GRID_SIDE)) ||
               (32'(in_end_x) >= 32'(GRID_SIDE)) || (32'(in_end_y) >= 32'(GRID_SIDE));
    bad_slope = (dx != '0) && (dy != '0) && (dx != dy);
    // offsets wrap modulo the address width, so a down step is a negated row
    xstep = (dx == '0) ? '0 : (xup ? COL_STEP : '0 - COL_STEP);
    ystep = (dy == '0) ? '0 : (yup ? ROW_STEP : '0 - ROW_STEP);
    new_cmd.rejected   = off_grid || bad_slope;
    new_cmd.start_addr = CELL_AW'(32'(in_start_y) * GRID_SIDE) + CELL_AW'(in_start_x);
    new_cmd.step       = xstep + ystep;
    new_cmd.len        = (dx > dy) ? dx : dy;
  end

  assign in_stall  = (count_r == 2'd2) || hold;
  assign push      = in_valid && !in_stall;
  assign cmd_valid = count_r != 2'd0;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ cmd_pop;
    count_nxt  = count_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srast_back.sv =====
// back end: clears the hit grid after reset, walks each unrejected segment with one
// read-modify-write per cell and keeps the overlap total; uses srast_pkg, srast_ram
`default_nettype none

module srast_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cmd_valid,
  input  wire srast_pkg::seg_cmd_t      cmd,
  output logic                          cmd_pop,
  output logic                          clear_busy,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [srast_pkg::TOTAL_W-1:0] out_overlap_cells,
  output logic                          out_rejected
);

  import srast_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam cell_addr_t LAST_CELL = CELL_AW'(CELLS - 1);

  logic [2:0]   state_r, state_nxt;
  cell_addr_t   clr_r, clr_nxt;
  logic         pend_r, pend_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic         out_valid_r, out_valid_nxt;

  cell_addr_t   addr_r, addr_nxt;
  cell_addr_t   step_r, step_nxt;
  coord_t       cnt_r, cnt_nxt;
  cell_addr_t   wb_addr_r, wb_addr_nxt;
  logic         rej_r, rej_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic         out_rej_r, out_rej_nxt;

  logic         ram_we, ram_re;
  cell_addr_t   ram_waddr;
  logic [HIT_W-1:0] ram_wdata, ram_rdata;
  logic         load_out;

  srast_ram #(
    .WIDTH (HIT_W),
    .DEPTH (CELLS)
  ) u_hits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // write side: clearing sweep, else update of the cell read last cycle
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_r && (ram_rdata < HIT_SAT);
      ram_waddr = wb_addr_r;
      ram_wdata = ram_rdata + HIT_ONE;
    end
    total_nxt = total_r;
    if (pend_r && (ram_rdata == HIT_ONE) && (total_r != TOTAL_MAX)) begin
      total_nxt = total_r + TOTAL_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pend_nxt      = 1'b0;
    cmd_pop       = 1'b0;
    ram_re        = 1'b0;
    load_out      = 1'b0;
    addr_nxt      = addr_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    wb_addr_nxt   = wb_addr_r;
    rej_nxt       = rej_r;
    out_total_nxt = out_total_r;
    out_rej_nxt   = out_rej_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CELL_AW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          rej_nxt  = cmd.rejected;
          addr_nxt = cmd.start_addr;
          step_nxt = cmd.step;
          cnt_nxt  = cmd.len;
          state_nxt = cmd.rejected ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        ram_re      = 1'b1;
        pend_nxt    = 1'b1;
        wb_addr_nxt = addr_r;
        addr_nxt    = addr_r + step_r;
        cnt_nxt     = cnt_r - COORD_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last cell is written this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_total_nxt = total_r;
          out_rej_nxt   = rej_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    wb_addr_r   <= wb_addr_nxt;
    rej_r       <= rej_nxt;
    out_total_r <= out_total_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign clear_busy        = state_r == ST_CLEAR;
  assign out_valid         = out_valid_r;
  assign out_overlap_cells = out_total_r;
  assign out_rejected      = out_rej_r;

endmodule

`default_nettype wire

// ===== tb/sv/segment_overlap_rasterizer_test.sv =====
// self-checking bench for segment_overlap_rasterizer: drives line segments,
// predicts the running overlap count per word and compares every result
// depends on srast_pkg and the rtl of segment_overlap_rasterizer only
module segment_overlap_rasterizer_test;
  import srast_pkg::*;

  localparam int MAX_COORD = GRID_SIDE - 1;
  localparam int WIN = 40;            // side of the busy window where overlaps pile up
  localparam int SHORT_SPAN = 24;
  localparam int RANDOM_PER_PHASE = 138;
  localparam int LONG_HOLD = 400;
  localparam int END_SLACK = 16;
  localparam int REPORT_LIMIT = 10;
  // the clearing pass after reset moves no word while it sweeps all CELLS cells
  localparam int WATCHDOG_LIMIT = 3 * CELLS;

  typedef struct {
    logic [TOTAL_W-1:0] overlap_cells;
    logic               rejected;
  } overlap_result_t;

  class overlap_scoreboard;
    bit [HIT_W-1:0]     hit_grid [CELLS];
    logic [TOTAL_W-1:0] overlap_total;
    overlap_result_t    expected_totals [$];
    int failures;
    int segments_drawn;
    int segments_rejected;
    int results_checked;

    function new();
      overlap_total = '0;
      failures = 0;
      segments_drawn = 0;
      segments_rejected = 0;
      results_checked = 0;
    endfunction

    // walk the segment like the block does and queue the total it should report
    function void draw_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int unsigned dx, dy, span, k;
      int cx, cy, ix, iy, idx;
      overlap_result_t want;
      dx = (sx > ex) ? sx - ex : ex - sx;
      dy = (sy > ey) ? sy - ey : ey - sy;
      // 10-bit coordinates never leave the grid, so only the slope can reject
      want.rejected = (dx != 0 && dy != 0 && dx != dy);
      if (!want.rejected) begin
        span = (dx > dy) ? dx : dy;
        ix = (ex > sx) ? 1 : ((ex < sx) ? -1 : 0);
        iy = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
        cx = sx;
        cy = sy;
        for (k = 0; k <= span; k++) begin
          idx = cy * GRID_SIDE + cx;
          if (hit_grid[idx] < HIT_SAT) begin
            hit_grid[idx]++;
            if (hit_grid[idx] == HIT_SAT && overlap_total != TOTAL_MAX)
              overlap_total++;
          end
          cx += ix;
          cy += iy;
        end
        segments_drawn++;
      end else begin
        segments_rejected++;
      end
      want.overlap_cells = overlap_total;
      expected_totals.push_back(want);
    endfunction

    function void check_total(logic [TOTAL_W-1:0] got_cells, logic got_rejected);
      overlap_result_t want;
      if (expected_totals.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result word: overlap_cells %0d rejected %0b",
                   got_cells, got_rejected);
      end else begin
        want = expected_totals.pop_front();
        results_checked++;
        if (got_cells !== want.overlap_cells || got_rejected !== want.rejected) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("result %0d: overlap_cells expected %0d got %0d, rejected expected %0b got %0b",
                     results_checked, want.overlap_cells, got_cells,
                     want.rejected, got_rejected);
        end
      end
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TOTAL_W-1:0] out_overlap_cells;
  logic out_rejected;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_armed = 1'b0;
  int hold_count = 0;
  int win_x = 0;
  int win_y = 0;

  overlap_scoreboard overlaps = new();

  segment_overlap_rasterizer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_overlap_cells(out_overlap_cells),
    .out_rejected(out_rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check accepted words, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      overlaps.check_total(out_overlap_cells, out_rejected);
    if (hold_armed && hold_count < LONG_HOLD) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int room(int p);
    return (p > MAX_COORD - p) ? p : MAX_COORD - p;
  endfunction

  // span must fit on at least one side of p
  function automatic int far_end(int p, int span);
    if (p + span <= MAX_COORD && (p < span || $urandom_range(1) == 1))
      return p + span;
    return p - span;
  endfunction

  function automatic void pick_segment(output coord_t sx, output coord_t sy,
                                       output coord_t ex, output coord_t ey);
    int unsigned roll, shape, span;
    int px, py;
    roll = $urandom_range(99);
    if (roll < 12) begin
      // noise: any four coordinates, nearly always an odd slope
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      ex = coord_t'($urandom);
      ey = coord_t'($urandom);
    end else begin
      if (roll < 16) begin
        px = $urandom_range(MAX_COORD);
        py = $urandom_range(MAX_COORD);
        span = $urandom_range(MAX_COORD);
      end else begin
        px = win_x + $urandom_range(WIN - 1);
        py = win_y + $urandom_range(WIN - 1);
        span = $urandom_range(SHORT_SPAN);
      end
      shape = $urandom_range(2);  // horizontal, vertical, diagonal
      if (shape != 1 && span > room(px))
        span = room(px);
      if (shape != 0 && span > room(py))
        span = room(py);
      sx = coord_t'(px);
      sy = coord_t'(py);
      ex = coord_t'((shape == 1) ? px : far_end(px, span));
      ey = coord_t'((shape == 0) ? py : far_end(py, span));
      // a few segments nudged one cell off their line
      if (roll >= 95)
        ex = ex ^ coord_t'(1);
    end
  endfunction

  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    do @(posedge clk); while (in_stall);
    overlaps.draw_segment(sx, sy, ex, ey);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (overlaps.pending() != 0);
  endtask

  initial begin : stimulus
    int sender_idle [4];
    int receiver_stall [4];
    int phase, n;
    coord_t sx, sy, ex, ey;
    sender_idle = '{0, 85, 0, 27};
    receiver_stall = '{0, 0, 85, 27};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // points, full-length lines, lines in every direction, odd slopes, alternating bits
    send_segment(10'd0, 10'd0, 10'd0, 10'd0);
    send_segment(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_segment(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_segment(10'd0, 10'd0, 10'd1023, 10'd0);
    send_segment(10'd1023, 10'd0, 10'd1023, 10'd1023);
    send_segment(10'd0, 10'd0, 10'd1023, 10'd1023);
    send_segment(10'd1023, 10'd0, 10'd0, 10'd1023);
    send_segment(10'd1023, 10'd1023, 10'd0, 10'd0);
    send_segment(10'd0, 10'd1023, 10'd0, 10'd0);
    send_segment(10'd1023, 10'd0, 10'd0, 10'd0);
    send_segment(10'd682, 10'd341, 10'd341, 10'd682);
    send_segment(10'd341, 10'd682, 10'd682, 10'd341);
    send_segment(10'd0, 10'd0, 10'd1, 10'd2);
    send_segment(10'd0, 10'd0, 10'd1023, 10'd1022);
    send_segment(10'd1023, 10'd1, 10'd0, 10'd0);
    send_segment(10'd512, 10'd512, 10'd520, 10'd512);
    send_segment(10'd515, 10'd509, 10'd515, 10'd516);
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      idle_pct = sender_idle[phase];
      stall_pct <= receiver_stall[phase];
      // output held off for a long stretch while segments keep coming
      if (phase == 0)
        hold_armed <= 1'b1;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(39) == 0) begin
          win_x = $urandom_range(MAX_COORD - WIN + 1);
          win_y = $urandom_range(MAX_COORD - WIN + 1);
        end
        pick_segment(sx, sy, ex, ey);
        send_segment(sx, sy, ex, ey);
      end
      drain_results();
    end

    repeat (END_SLACK) @(posedge clk);
    $display("%0d segments drawn and %0d rejected across four idle/stall mixes",
             overlaps.segments_drawn, overlaps.segments_rejected);
    $display("with a %0d-cycle output hold; final overlap count %0d",
             LONG_HOLD, overlaps.overlap_total);
    if (overlaps.failures == 0 && overlaps.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
